// ===== src/chip8_instruction_execute_assert.svh =====
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH

// property that holds at every edge out of reset
`define C8IE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define C8IE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/c8ie_pkg.sv =====
package c8ie_pkg;

  localparam int STACK_DEPTH_DEF  = 16;
  localparam int SPRITE_BYTES_DEF = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_BASE    = 1'd1;

  localparam logic [11:0] PC_RESET         = 12'h200;
  localparam logic [11:0] GLYPH_BASE_RESET = 12'h000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNIMPL  = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_STACK   = 2'd3;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDIX = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;

  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] FX_LD_DT    = 8'h07;
  localparam logic [7:0] FX_WAIT_KEY = 8'h0A;
  localparam logic [7:0] FX_SET_DT   = 8'h15;
  localparam logic [7:0] FX_SET_ST   = 8'h18;
  localparam logic [7:0] FX_ADD_I    = 8'h1E;
  localparam logic [7:0] FX_FONT     = 8'h29;
  localparam logic [7:0] FX_BCD      = 8'h33;
  localparam logic [7:0] FX_STORE    = 8'h55;
  localparam logic [7:0] FX_LOAD     = 8'h65;

  localparam logic [3:0] REG_V0 = 4'h0;
  localparam logic [3:0] REG_VF = 4'hF;

  typedef struct packed {
    logic [15:0] instruction;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
  } cmd_word_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [7:0]  sound_value;
    logic        clear_screen;
    logic [1:0]  status;
  } rsp_word_t;

  typedef struct packed {
    logic       vx_we;
    logic [3:0] x;
    logic [7:0] vx_val;
    logic       vf_we;
    logic [7:0] vf_val;
  } reg_wr_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [11:0] push_pc;
  } stk_op_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [11:0] top;
  } stk_stat_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [11:0] index;
    logic [7:0]  delay;
    logic [7:0]  sound;
    logic        clear;
    logic [1:0]  status;
  } exec_res_t;

endpackage

// ===== src/c8ie_chan_if.sv =====
interface c8ie_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/c8ie_regfile.sv =====
module c8ie_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [3:0]         rd_x,
  input  logic [3:0]         rd_y,
  input  logic               wr_en,
  input  c8ie_pkg::reg_wr_t  wr,
  output logic [7:0]         vx,
  output logic [7:0]         vy,
  output logic [7:0]         v0
);
  import c8ie_pkg::*;

  logic [7:0]  mem [16];
  logic [15:0] valid;
  logic [7:0]  vf;
  logic [7:0]  v0_copy;
  logic [7:0]  rdx;
  logic [7:0]  rdy;
  logic        x_is_f;
  logic        y_is_f;
  logic        mem_we;

  assign mem_we = wr_en && wr.vx_we && (wr.x != REG_VF);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr.x] <= wr.vx_val;
    end
    if (rd_en) begin
      rdx    <= (mem_we && wr.x == rd_x) ? wr.vx_val : (valid[rd_x] ? mem[rd_x] : 8'h00);
      rdy    <= (mem_we && wr.x == rd_y) ? wr.vx_val : (valid[rd_y] ? mem[rd_y] : 8'h00);
      x_is_f <= (rd_x == REG_VF);
      y_is_f <= (rd_y == REG_VF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      vf      <= 8'h00;
      v0_copy <= 8'h00;
    end else begin
      if (mem_we) begin
        valid[wr.x] <= 1'b1;
      end
      if (mem_we && wr.x == REG_V0) begin
        v0_copy <= wr.vx_val;
      end
      // flag write lands after the result write
      if (wr_en && wr.vf_we) begin
        vf <= wr.vf_val;
      end else if (wr_en && wr.vx_we && wr.x == REG_VF) begin
        vf <= wr.vx_val;
      end
    end
  end

  assign vx = x_is_f ? vf : rdx;
  assign vy = y_is_f ? vf : rdy;
  assign v0 = v0_copy;
endmodule

// ===== src/c8ie_stack.sv =====
`include "chip8_instruction_execute_assert.svh"

module c8ie_stack #(
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  c8ie_pkg::stk_op_t   op,
  output c8ie_pkg::stk_stat_t stat
);
  import c8ie_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  logic [11:0]     mem [STACK_DEPTH];
  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_next;
  logic [SP_W-1:0] sp_dec;
  logic [11:0]     top;

  always_comb begin
    sp_next = sp;
    if (en && op.push) begin
      sp_next = sp + SP_W'(1);
    end else if (en && op.pop) begin
      sp_next = sp - SP_W'(1);
    end
  end

  assign sp_dec = sp_next - SP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  // top of stack is kept registered, pushed word bypassed
  always_ff @(posedge clk) begin
    if (en && op.push) begin
      mem[sp[AW-1:0]] <= op.push_pc;
      top             <= op.push_pc;
    end else if (sp_next != '0) begin
      top <= mem[sp_dec[AW-1:0]];
    end
  end

  assign stat.empty = (sp == '0);
  assign stat.full  = (sp == SP_W'(STACK_DEPTH));
  assign stat.top   = top;

  `C8IE_ASSERT(a_sp_bound, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `C8IE_ASSERT_NEXT(a_push_inc, en && op.push, sp == $past(sp) + SP_W'(1), "push lost")
  `C8IE_ASSERT_NEXT(a_pop_dec, en && op.pop && !op.push, sp == $past(sp) - SP_W'(1),
                    "pop lost")
endmodule

// ===== src/c8ie_exec.sv =====
module c8ie_exec #(
  parameter int SPRITE_BYTES = c8ie_pkg::SPRITE_BYTES_DEF
) (
  input  c8ie_pkg::cmd_word_t word,
  input  logic [7:0]          vx,
  input  logic [7:0]          vy,
  input  logic [7:0]          v0,
  input  logic [11:0]         pc,
  input  logic [11:0]         index,
  input  logic [7:0]          delay,
  input  logic [7:0]          sound,
  input  logic [11:0]         glyph_base,
  input  c8ie_pkg::stk_stat_t stk,
  output c8ie_pkg::reg_wr_t   wr,
  output c8ie_pkg::stk_op_t   sop,
  output c8ie_pkg::exec_res_t res
);
  import c8ie_pkg::*;

  logic [3:0]  grp;
  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [11:0] pc_adv;
  logic [11:0] pc_skip;
  logic [8:0]  sum;
  logic        pressed;

  assign grp     = word.instruction[15:12];
  assign x       = word.instruction[11:8];
  assign n       = word.instruction[3:0];
  assign nn      = word.instruction[7:0];
  assign nnn     = word.instruction[11:0];
  assign pc_adv  = pc + 12'd2;
  assign pc_skip = pc + 12'd4;
  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign pressed = word.key_mask[vx[3:0]];

  always_comb begin
    wr          = '0;
    wr.x        = x;
    sop         = '0;
    sop.push_pc = pc_adv;
    res.pc      = pc_adv;
    res.index   = index;
    res.delay   = delay;
    res.sound   = sound;
    res.clear   = 1'b0;
    res.status  = ST_OK;
    case (grp)
      GRP_SYS: begin
        if (nnn == SYS_CLS) begin
          res.clear = 1'b1;
        end else if (nnn == SYS_RET) begin
          if (stk.empty) begin
            res.status = ST_STACK;
          end else begin
            sop.pop = 1'b1;
            res.pc  = stk.top;
          end
        end else begin
          res.status = ST_UNIMPL;
        end
      end
      GRP_JP: res.pc = nnn;
      GRP_CALL: begin
        if (stk.full) begin
          res.status = ST_STACK;
        end else begin
          sop.push = 1'b1;
          res.pc   = nnn;
        end
      end
      GRP_SEI: if (vx == nn) res.pc = pc_skip;
      GRP_SNEI: if (vx != nn) res.pc = pc_skip;
      GRP_SER: if (vx == vy) res.pc = pc_skip;
      GRP_LDI: begin
        wr.vx_we  = 1'b1;
        wr.vx_val = nn;
      end
      GRP_ADDI: begin
        wr.vx_we  = 1'b1;
        wr.vx_val = vx + nn;
      end
      GRP_ALU: begin
        wr.vx_we = 1'b1;
        case (n)
          ALU_LD:  wr.vx_val = vy;
          ALU_OR:  wr.vx_val = vx | vy;
          ALU_AND: wr.vx_val = vx & vy;
          ALU_XOR: wr.vx_val = vx ^ vy;
          ALU_ADD: begin
            wr.vx_val = sum[7:0];
            wr.vf_we  = 1'b1;
            wr.vf_val = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            wr.vx_val = vx - vy;
            wr.vf_we  = 1'b1;
            wr.vf_val = {7'd0, vx >= vy};
          end
          ALU_SHR: begin
            wr.vx_val = {1'b0, vy[7:1]};
            wr.vf_we  = 1'b1;
            wr.vf_val = {7'd0, vy[0]};
          end
          ALU_SUBN: begin
            wr.vx_val = vy - vx;
            wr.vf_we  = 1'b1;
            wr.vf_val = {7'd0, vy >= vx};
          end
          ALU_SHL: begin
            wr.vx_val = {vy[6:0], 1'b0};
            wr.vf_we  = 1'b1;
            wr.vf_val = {7'd0, vy[7]};
          end
          default: begin
            wr.vx_we   = 1'b0;
            res.status = ST_ILLEGAL;
          end
        endcase
      end
      GRP_SNER: if (vx != vy) res.pc = pc_skip;
      GRP_LDIX: res.index = nnn;
      GRP_JPV0: res.pc = {4'd0, v0} + nnn;
      GRP_RND: begin
        wr.vx_we  = 1'b1;
        wr.vx_val = word.random_byte & nn;
      end
      GRP_DRW: res.status = ST_UNIMPL;
      GRP_KEY: begin
        case (nn)
          KEY_DOWN: if (pressed) res.pc = pc_skip;
          KEY_UP:   if (!pressed) res.pc = pc_skip;
          default:  res.status = ST_ILLEGAL;
        endcase
      end
      GRP_MISC: begin
        case (nn)
          FX_LD_DT: begin
            wr.vx_we  = 1'b1;
            wr.vx_val = delay;
          end
          FX_SET_DT: res.delay = vx;
          FX_SET_ST: res.sound = vx;
          FX_ADD_I:  res.index = index + {4'd0, vx};
          FX_FONT:   res.index = glyph_base + 12'(vx[3:0] * SPRITE_BYTES);
          default: begin
            res.status = (nn inside {FX_WAIT_KEY, FX_BCD, FX_STORE, FX_LOAD}) ?
                         ST_UNIMPL : ST_ILLEGAL;
          end
        endcase
      end
      default: res.status = ST_ILLEGAL;
    endcase
  end
endmodule

// ===== src/chip8_instruction_execute.sv =====
// chip8_instruction_execute: executes one fetched instruction word per cycle
// unless rsp stalls. cmd channel (valid/ready): a word holds the instruction,
// the key mask and a random byte. rsp channel (valid/ready): a word holds the
// next pc, the index register, the sound timer, the clear-screen request and
// the status. cfg port: cfg_we/cfg_index/cfg_data writes glyph_base (index 1);
// writes to the start address (index 0) are ignored; pc resets to 0x200.
// A taken word waits in the input register and is executed into the result
// register when that is free. Throughput: one instruction per cycle unless
// rsp stalls, set by the single execute step that reads the register file,
// index, timers and stack top and writes them back.
// Register file reads are registered as a word enters the input register, with
// forwarding from the instruction executing in that cycle.
// Reset clears V0..VF, index, timers and stack pointer and loads pc with 0x200.
// When rsp is stalled the result register holds; one more word waits in the
// input register, then cmd ready drops until the result is taken.
`include "chip8_instruction_execute_assert.svh"

module chip8_instruction_execute #(
  parameter int STACK_DEPTH  = c8ie_pkg::STACK_DEPTH_DEF,
  parameter int SPRITE_BYTES = c8ie_pkg::SPRITE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  c8ie_chan_if.sink                         cmd,
  c8ie_chan_if.source                       rsp,
  input  logic                              cfg_we,
  input  logic [c8ie_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c8ie_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import c8ie_pkg::*;

  logic        in_valid;
  cmd_word_t   in_word;
  logic        rsp_valid;
  rsp_word_t   rsp_word;
  logic        cmd_fire;
  logic        exec_fire;

  logic [11:0] pc;
  logic [11:0] index_reg;
  logic [7:0]  delay_timer;
  logic [7:0]  sound_timer;
  logic [11:0] glyph_base;

  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [7:0]  v0;
  reg_wr_t     wr;
  stk_op_t     sop;
  stk_stat_t   stk;
  exec_res_t   res;

  assign exec_fire = in_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !in_valid || exec_fire;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

  c8ie_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .rd_en (cmd_fire),
    .rd_x  (cmd.data.instruction[11:8]),
    .rd_y  (cmd.data.instruction[7:4]),
    .wr_en (exec_fire),
    .wr    (wr),
    .vx    (vx),
    .vy    (vy),
    .v0    (v0)
  );

  c8ie_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .en   (exec_fire),
    .op   (sop),
    .stat (stk)
  );

  c8ie_exec #(
    .SPRITE_BYTES (SPRITE_BYTES)
  ) u_exec (
    .word       (in_word),
    .vx         (vx),
    .vy         (vy),
    .v0         (v0),
    .pc         (pc),
    .index      (index_reg),
    .delay      (delay_timer),
    .sound      (sound_timer),
    .glyph_base (glyph_base),
    .stk        (stk),
    .wr         (wr),
    .sop        (sop),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
      pc          <= PC_RESET;
      index_reg   <= 12'h000;
      delay_timer <= 8'h00;
      sound_timer <= 8'h00;
      glyph_base  <= GLYPH_BASE_RESET;
    end else begin
      if (cmd_fire) begin
        in_valid <= 1'b1;
      end else if (exec_fire) begin
        in_valid <= 1'b0;
      end
      if (exec_fire) begin
        rsp_valid   <= 1'b1;
        pc          <= res.pc;
        index_reg   <= res.index;
        delay_timer <= res.delay;
        sound_timer <= res.sound;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLYPH_BASE: glyph_base <= cfg_data;
          CFG_START_ADDRESS: ;  // writes ignored; pc resets to PC_RESET
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      in_word <= cmd.data;
    end
    if (exec_fire) begin
      rsp_word.next_pc      <= res.pc;
      rsp_word.index_value  <= res.index;
      rsp_word.sound_value  <= res.sound;
      rsp_word.clear_screen <= res.clear;
      rsp_word.status       <= res.status;
    end
  end

  `C8IE_ASSERT_NEXT(a_exec_shows, exec_fire, rsp_valid, "executed word not shown")
  `C8IE_ASSERT_NEXT(a_hold_input, in_valid && !exec_fire, in_valid, "waiting word dropped")
  `C8IE_ASSERT_NEXT(a_fault_quiet, exec_fire && res.status != ST_OK,
                    $stable(index_reg) && $stable(sound_timer) && $stable(delay_timer),
                    "faulting instruction changed state")
endmodule
